// File: hdl/double_ended_queue_macros.svh
// ----------------------------------------------------------------------------
// double_ended_queue_macros.svh
// Assertion macros used by the deque RTL.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Checked only outside reset.
`define DEQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, including during reset.
`define DEQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Types and constants of the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH   = 16;
    localparam int WORD_W  = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_REAR  = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_REAR   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [CNT_W-1:0]         count_t;

    // Per-cell control; load wins over the shifts.
    typedef struct packed {
        logic load;
        logic take_prev;
        logic take_next;
        logic tap;
    } cell_ctrl_t;

endpackage

// File: hdl/deq_ifs.sv
// ----------------------------------------------------------------------------
// deq_ifs
// Request and response channels of the double-ended queue.
// ----------------------------------------------------------------------------
interface deq_req_if;
    logic            valid;
    logic            ready;
    deq_pkg::action_t action;
    deq_pkg::word_t   push_value;

    modport source (output valid, output action, output push_value, input ready);
    modport sink   (input valid, input action, input push_value, output ready);
endinterface

interface deq_rsp_if;
    logic             valid;
    logic             ready;
    deq_pkg::word_t   pop_value;
    deq_pkg::status_t status;
    deq_pkg::count_t  fill_count;

    modport source (output valid, output pop_value, output status, output fill_count,
                    input ready);
    modport sink   (input valid, input pop_value, input status, input fill_count,
                    output ready);
endinterface

// File: hdl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Double-ended queue of signed 32-bit words built as a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries action (push front, push rear, pop front, pop rear)
//   and push_value. Each request yields exactly one response on rsp:
//   pop_value (zero unless a pop succeeded), status (ok, empty, full) and
//   fill_count, the number of words held after the operation.
//   The front word always sits in cell 0. A front push or pop shifts the
//   whole chain by one cell; a rear push writes the cell at the
//   fill count and a rear pop reads the cell just below it.
//   The response is registered and valid in the cycle after the
//   request is accepted. Throughput: one request per cycle while rsp.ready
//   is high, set by the single response register.
//   Stall: while a response waits with rsp.ready low, req.ready drops, so
//   the queue state does not move until the response is taken.
//   Reset: the queue is empty and no response is pending; cell contents
//   are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
`include "double_ended_queue_macros.svh"

module double_ended_queue (
    input  logic          clk,
    input  logic          rst_n,
    deq_req_if.sink       req,
    deq_rsp_if.source     rsp
);
    import deq_pkg::*;

    count_t     count_reg;
    count_t     count_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    word_t      pop_value_reg;
    word_t      pop_value_next;
    status_t    status_reg;
    status_t    status_next;

    logic       fire;
    logic       is_push;
    logic       is_full;
    logic       is_empty;
    logic       push_ok;
    logic       pop_ok;
    word_t      rear_word;

    cell_ctrl_t ctrl     [DEPTH];
    word_t      cell_data[DEPTH];
    word_t      cell_tap [DEPTH];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;
    assign is_push   = (req.action == ACT_PUSH_FRONT) || (req.action == ACT_PUSH_REAR);
    assign is_full   = (count_reg == count_t'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign push_ok   = fire && is_push && !is_full;
    assign pop_ok    = fire && !is_push && !is_empty;

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ctrl[i].load      = push_ok &&
                                (((req.action == ACT_PUSH_FRONT) && (i == 0)) ||
                                 ((req.action == ACT_PUSH_REAR) &&
                                  (count_reg == count_t'(i))));
            ctrl[i].take_prev = push_ok && (req.action == ACT_PUSH_FRONT) && (i != 0);
            ctrl[i].take_next = pop_ok && (req.action == ACT_POP_FRONT);
            ctrl[i].tap       = (count_reg == count_t'(i + 1));
        end
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        word_t prev_w;
        word_t next_w;

        if (g == 0)
        begin : g_first
            assign prev_w = req.push_value;
        end
        else
        begin : g_mid_prev
            assign prev_w = cell_data[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign next_w = cell_data[g];
        end
        else
        begin : g_mid_next
            assign next_w = cell_data[g+1];
        end

        deq_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl[g]),
            .push_value (req.push_value),
            .prev_data  (prev_w),
            .next_data  (next_w),
            .data       (cell_data[g]),
            .tap_data   (cell_tap[g])
        );
    end

    always_comb
    begin
        rear_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rear_word = rear_word | cell_tap[i];
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        pop_value_next = pop_value_reg;
        status_next    = status_reg;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (fire)
        begin
            rsp_valid_next = 1'b1;
            pop_value_next = '0;
            status_next    = ST_OK;
            unique case (req.action)
                ACT_PUSH_FRONT, ACT_PUSH_REAR:
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + count_t'(1);
                    end
                end
                ACT_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        pop_value_next = cell_data[0];
                        count_next     = count_reg - count_t'(1);
                    end
                end
                ACT_POP_REAR:
                begin
                    if (is_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        pop_value_next = rear_word;
                        count_next     = count_reg - count_t'(1);
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pop_value_reg <= pop_value_next;
        status_reg    <= status_next;
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.pop_value  = pop_value_reg;
    assign rsp.status     = status_reg;
    assign rsp.fill_count = count_reg;

    `DEQ_ASSERT(a_count_range, count_reg <= count_t'(DEPTH), "fill count beyond depth")
    `DEQ_ASSERT(a_rsp_follows, fire |=> rsp_valid_reg, "request without response")
    `DEQ_ASSERT(a_full_flag, (fire && is_push && is_full) |=> (status_reg == ST_FULL && count_reg == $past(count_reg)), "push on full not refused")
    `DEQ_ASSERT(a_pop_count, pop_ok |=> (count_reg == $past(count_reg) - count_t'(1)), "pop did not shrink count")

endmodule

// File: hdl/deq_cell.sv
// ----------------------------------------------------------------------------
// deq_cell
// One storage cell of the deque chain: load, shift from either neighbor or hold.
// ----------------------------------------------------------------------------
module deq_cell (
    input  logic                clk,
    input  deq_pkg::cell_ctrl_t ctrl,
    input  deq_pkg::word_t      push_value,
    input  deq_pkg::word_t      prev_data,
    input  deq_pkg::word_t      next_data,
    output deq_pkg::word_t      data,
    output deq_pkg::word_t      tap_data
);
    import deq_pkg::*;

    word_t data_reg;
    word_t data_next;

    always_comb
    begin
        priority if (ctrl.load)
        begin
            data_next = push_value;
        end
        else if (ctrl.take_prev)
        begin
            data_next = prev_data;
        end
        else if (ctrl.take_next)
        begin
            data_next = next_data;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign tap_data = ctrl.tap ? data_reg : '0;

endmodule
